@@ rtl/joystick_to_differential_drive_defines.svh @@
// Assertion macros used by the RTL.
`ifndef JOYSTICK_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH
`define JOYSTICK_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define JDD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be seen outside reset
`define JDD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JDD_ASSERT(label, clk, rst_n, prop, msg)
`define JDD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/jdd_pkg.sv @@
`timescale 1ns / 1ps

package jdd_pkg;

	localparam int DUTY_W = 15;
	localparam int DEAD_W = 7;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] CENTRE     = 8'd127;
	localparam logic [DUTY_W-1:0] SPIN_SPEED = 15'd400;
	localparam int                BIT_SPIN_RIGHT = 1;
	localparam int                BIT_SPIN_LEFT  = 2;

	localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 15'd1000;
	localparam logic [DUTY_W-1:0] MIN_DUTY_RST  = 15'd100;
	localparam logic [DEAD_W-1:0] DEAD_BAND_RST = 7'd10;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BACK = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		CFG_MAX_DUTY  = 2'd0,
		CFG_MIN_DUTY  = 2'd1,
		CFG_DEAD_BAND = 2'd2
	} cfg_idx_t;

	// signed speed as sign and magnitude
	typedef struct packed {
		logic              neg;
		logic [DUTY_W-1:0] mag;
	} sm_t;

	typedef struct packed {
		logic [BYTE_W-1:0] stick_side;
		logic [BYTE_W-1:0] stick_fore;
		logic [BYTE_W-1:0] button_bits;
	} stick_t;

	typedef struct packed {
		dir_t              left_dir;
		logic [DUTY_W-1:0] left_duty;
		dir_t              right_dir;
		logic [DUTY_W-1:0] right_duty;
	} drive_t;

endpackage

@@ rtl/jdd_stick_if.sv @@
`timescale 1ns / 1ps

interface jdd_stick_if import jdd_pkg::*; ();
	logic   valid;
	logic   ready;
	stick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/jdd_drive_if.sv @@
`timescale 1ns / 1ps

interface jdd_drive_if import jdd_pkg::*; ();
	logic   valid;
	logic   ready;
	drive_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/jdd_axis_map.sv @@
`timescale 1ns / 1ps

module jdd_axis_map import jdd_pkg::*; (
	input  logic [BYTE_W-1:0] raw,
	input  logic [DUTY_W-1:0] max_duty,
	input  logic [DEAD_W-1:0] dead_band,
	output sm_t               axis
);

	logic                     above;
	logic                     below;
	logic [BYTE_W-1:0]        delta;
	logic [DUTY_W+BYTE_W-1:0] prod;

	// thresholds compared at 9 bits so 127 +/- dead_band never wraps
	assign above = {1'b0, raw} > ({1'b0, CENTRE} + {2'b00, dead_band});
	assign below = ({1'b0, raw} + {2'b00, dead_band}) < {1'b0, CENTRE};

	always_comb begin
		if (above) begin
			delta = raw - CENTRE;
		end else if (below) begin
			delta = CENTRE - raw;
		end else begin
			delta = '0;
		end
	end

	// delta <= 128, so prod / 128 never exceeds max_duty
	assign prod = {{DUTY_W{1'b0}}, delta} * {{BYTE_W{1'b0}}, max_duty};

	assign axis.neg = below;
	assign axis.mag = prod[DUTY_W+6:7];

endmodule

@@ rtl/joystick_to_differential_drive.sv @@
`timescale 1ns / 1ps
// channel  | role   | payload
// ---------+--------+-----------------------------------------------
// stick    | sink   | stick_side, stick_fore, button_bits
// motor    | source | left_dir, left_duty, right_dir, right_duty
// wr_*     | write  | max_duty (0), min_duty (1), dead_band (2)
//
// One item per cycle while motor.ready is high (input register, then
// result register, one multiply per axis between).
// arst_n clears the valid bits and loads the register defaults.
// A stalled result holds; the input stage keeps taking items until both
// stages are full.

`include "joystick_to_differential_drive_defines.svh"

module joystick_to_differential_drive import jdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	jdd_stick_if.sink         stick,
	jdd_drive_if.source       motor,
	input  logic              wr_en,
	input  logic [1:0]        wr_idx,
	input  logic [DUTY_W-1:0] wr_data
);

	logic [DUTY_W-1:0] max_duty_q;
	logic [DUTY_W-1:0] min_duty_q;
	logic [DEAD_W-1:0] dead_band_q;

	logic   s1_valid_q;
	stick_t stick_s1;
	logic   s2_valid_q;
	drive_t res_s2;

	logic   adv_s2;
	sm_t    side_ax;
	sm_t    fore_ax;
	sm_t    left_v;
	sm_t    right_v;
	logic [DUTY_W-1:0] spin_spd;
	logic [DUTY_W-1:0] diag_spd;
	drive_t res_d;
	logic   left_agree;
	logic   right_agree;

	function automatic logic [DUTY_W-1:0] clamp_speed(
		input logic [DUTY_W-1:0] s,
		input logic [DUTY_W-1:0] mx,
		input logic [DUTY_W-1:0] mn
	);
		logic [DUTY_W-1:0] t;
		t = (s > mx) ? mx : s;
		return (t < mn) ? mn : t;
	endfunction

	// ---- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q  <= MAX_DUTY_RST;
			min_duty_q  <= MIN_DUTY_RST;
			dead_band_q <= DEAD_BAND_RST;
		end else if (wr_en) begin
			case (wr_idx)
				CFG_MAX_DUTY:  max_duty_q  <= wr_data;
				CFG_MIN_DUTY:  min_duty_q  <= wr_data;
				CFG_DEAD_BAND: dead_band_q <= wr_data[DEAD_W-1:0];
				default:       ;
			endcase
		end
	end

	// ---- handshake
	assign adv_s2      = s1_valid_q && (!s2_valid_q || motor.ready);
	assign stick.ready = !s1_valid_q || !s2_valid_q || motor.ready;
	assign motor.valid = s2_valid_q;
	assign motor.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (stick.valid && stick.ready) begin
				s1_valid_q <= 1'b1;
			end else if (adv_s2) begin
				s1_valid_q <= 1'b0;
			end
			if (adv_s2) begin
				s2_valid_q <= 1'b1;
			end else if (motor.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stick.valid && stick.ready) begin
			stick_s1 <= stick.data;
		end
		if (adv_s2) begin
			res_s2 <= res_d;
		end
	end

	// ---- mapping
	jdd_axis_map u_side (
		.raw       (stick_s1.stick_side),
		.max_duty  (max_duty_q),
		.dead_band (dead_band_q),
		.axis      (side_ax)
	);

	jdd_axis_map u_fore (
		.raw       (stick_s1.stick_fore),
		.max_duty  (max_duty_q),
		.dead_band (dead_band_q),
		.axis      (fore_ax)
	);

	assign spin_spd = clamp_speed(SPIN_SPEED, max_duty_q, min_duty_q);
	assign diag_spd = clamp_speed(side_ax.mag, max_duty_q, min_duty_q);

	always_comb begin
		left_v  = '0;
		right_v = '0;
		if (stick_s1.button_bits[BIT_SPIN_LEFT]) begin
			left_v  = '{neg: 1'b1, mag: spin_spd};
			right_v = '{neg: 1'b0, mag: spin_spd};
		end else if (stick_s1.button_bits[BIT_SPIN_RIGHT]) begin
			left_v  = '{neg: 1'b0, mag: spin_spd};
			right_v = '{neg: 1'b1, mag: spin_spd};
		end else if (fore_ax.mag == '0 && side_ax.mag == '0) begin
			left_v  = '0;
			right_v = '0;
		end else if (fore_ax.mag > side_ax.mag) begin
			// fore axis is inverted: stick up means forward
			left_v  = '{neg: !fore_ax.neg, mag: fore_ax.mag};
			right_v = '{neg: !fore_ax.neg, mag: fore_ax.mag};
		end else if (!side_ax.neg && side_ax.mag != '0) begin
			left_v  = '{neg: 1'b0, mag: diag_spd};
			right_v = '{neg: 1'b0, mag: diag_spd >> 1};
		end else begin
			left_v  = '{neg: 1'b0, mag: diag_spd >> 1};
			right_v = '{neg: 1'b0, mag: diag_spd};
		end
	end

	// a side runs only when its speed is strictly above min_duty
	always_comb begin
		res_d = '0;
		if (left_v.mag > min_duty_q) begin
			res_d.left_dir  = left_v.neg ? DIR_BACK : DIR_FWD;
			res_d.left_duty = left_v.mag;
		end else begin
			res_d.left_dir  = DIR_STOP;
			res_d.left_duty = '0;
		end
		if (right_v.mag > min_duty_q) begin
			res_d.right_dir  = right_v.neg ? DIR_BACK : DIR_FWD;
			res_d.right_duty = right_v.mag;
		end else begin
			res_d.right_dir  = DIR_STOP;
			res_d.right_duty = '0;
		end
	end

	// ---- checks
	assign left_agree  = (motor.data.left_dir == DIR_STOP) == (motor.data.left_duty == '0);
	assign right_agree = (motor.data.right_dir == DIR_STOP) == (motor.data.right_duty == '0);

	`JDD_ASSERT(a_left_stop_zero, clk, arst_n, motor.valid |-> left_agree, "left stop mismatch")
	`JDD_ASSERT(a_right_stop_zero, clk, arst_n, motor.valid |-> right_agree, "right stop mismatch")
	`JDD_ASSERT(a_take_when_free, clk, arst_n, !s2_valid_q |-> stick.ready, "input refused")
	`JDD_ASSERT_NEVER(a_no_drop, clk, arst_n, s2_valid_q && !motor.ready && adv_s2, "result lost")

endmodule
